>>> rtl/kdq_pkg.sv
// Shared types, constants and the key compare function for the keyed deque.
package kdq_pkg;

  localparam int unsigned KDQ_DEPTH = 16;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned REF_W     = 32;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_REMOVE = 2'd3
  } kdq_action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } kdq_status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] hdl;
  } kdq_entry_t;

  // cap: latch match bits against the incoming key; exec: apply the move
  typedef struct packed {
    logic        cap;
    logic        exec;
    kdq_action_e action;
  } kdq_ctrl_t;

  function automatic logic [7:0] fold_byte(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'h20;
    return r;
  endfunction

  // Case-blind compare of zero-terminated 8-byte strings
  function automatic logic keys_match(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    logic       ended;
    logic       ok;
    logic [7:0] ca;
    logic [7:0] cb;
    ended = 1'b0;
    ok    = 1'b1;
    for (int p = 0; p < 8; p++) begin
      ca = fold_byte(a[p*8 +: 8]);
      cb = fold_byte(b[p*8 +: 8]);
      if (!ended) begin
        if (ca != cb) begin
          ok    = 1'b0;
          ended = 1'b1;
        end else if (ca == 8'h00) begin
          ended = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage

>>> rtl/kdq_if.sv
// Request and response channel interfaces of the keyed deque.
interface kdq_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [kdq_pkg::KEY_W-1:0]  patient_key;
  logic [kdq_pkg::REF_W-1:0]  patient_ref;
  modport source (output valid, output action, output patient_key, output patient_ref,
                  input ready);
  modport sink   (input valid, input action, input patient_key, input patient_ref,
                  output ready);
endinterface

interface kdq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [kdq_pkg::KEY_W-1:0]  out_key;
  logic [kdq_pkg::REF_W-1:0]  out_ref;
  logic [kdq_pkg::OCC_W-1:0]  occupancy;
  modport source (output valid, output status, output out_key, output out_ref,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_key, input out_ref,
                  input occupancy, output ready);
endinterface

>>> rtl/kdq_cell.sv
// One slot of the deque: holds an entry, its match bit and its shift logic.
module kdq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                      clk_i,
  input  kdq_pkg::kdq_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]          count_i,
  input  kdq_pkg::kdq_entry_t       req_i,
  input  logic [kdq_pkg::KEY_W-1:0] cmp_key_i,
  input  kdq_pkg::kdq_entry_t       left_i,
  input  kdq_pkg::kdq_entry_t       right_i,
  input  logic                      found_i,
  input  kdq_pkg::kdq_entry_t       hit_i,
  output kdq_pkg::kdq_entry_t       entry_o,
  output logic                      found_o,
  output kdq_pkg::kdq_entry_t       hit_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  kdq_pkg::kdq_entry_t entry_q, entry_d;
  logic                match_q;
  logic                occ;
  logic                own;

  assign occ     = count_i > MyIdx;
  assign own     = match_q && occ && (ctrl_i.action == kdq_pkg::ACT_REMOVE);
  assign found_o = found_i || own;
  assign hit_o   = found_i ? hit_i : (own ? entry_q : '0);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.exec) begin
      case (ctrl_i.action)
        kdq_pkg::ACT_APPEND: if (count_i == MyIdx) entry_d = req_i;
        kdq_pkg::ACT_INSERT: entry_d = left_i;
        kdq_pkg::ACT_TAKE:   entry_d = right_i;
        kdq_pkg::ACT_REMOVE: if (found_o) entry_d = right_i;
        default:             entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.cap) match_q <= kdq_pkg::keys_match(entry_q.key, cmp_key_i);
  end

endmodule

>>> rtl/keyed_deque_with_removal_core.sv
// Top level of the keyed deque: request/response handling and the row of slot cells.
// Bounded deque of DEPTH entries (8-byte key plus 32-bit handle), head in cell 0.
// Each request has an accept cycle, in which every cell compares its key with the
// request key in parallel, and an execute cycle, in which the row shifts left or right
// by one place (or a single cell loads at the tail) and the response is registered.
// So one request is in flight at a time: no new request is accepted until the last
// one has executed, and a stalled response holds the execute cycle. Removal takes
// the first match from the head, found by a ripple chain that passes a found flag
// and the hit entry from cell to cell. The occupancy count, the state and the
// response valid flag are the only reset state; slot contents are never cleared and
// are read only below the count.
module keyed_deque_with_removal_core #(
  parameter int unsigned DEPTH = kdq_pkg::KDQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kdq_req_if.sink   req_i,
  kdq_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             count_q, count_d;
  kdq_pkg::kdq_action_e      act_q;
  kdq_pkg::kdq_entry_t       req_q;

  logic                      rsp_valid_q;
  kdq_pkg::kdq_status_e      status_q, status_d;
  kdq_pkg::kdq_entry_t       out_q, out_d;
  logic [kdq_pkg::OCC_W-1:0] occ_q;

  logic                      accept;
  logic                      go;
  logic                      is_full;
  logic                      is_empty;
  logic                      effective;
  logic [31:0]               cnt32;
  kdq_pkg::kdq_ctrl_t        ctrl;

  kdq_pkg::kdq_entry_t       entry_w [DEPTH];
  logic                      found_w [DEPTH+1];
  kdq_pkg::kdq_entry_t       hit_w   [DEPTH+1];

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  // execute once the response register is free or being drained
  assign go          = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign is_full  = (count_q == Full);
  assign is_empty = (count_q == '0);

  always_comb begin
    effective = 1'b0;
    status_d  = kdq_pkg::ST_DONE;
    out_d     = '0;
    count_d   = count_q;
    case (act_q)
      kdq_pkg::ACT_APPEND, kdq_pkg::ACT_INSERT: begin
        if (is_full) begin
          status_d = kdq_pkg::ST_FULL;
        end else begin
          effective = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      kdq_pkg::ACT_TAKE: begin
        if (is_empty) begin
          status_d = kdq_pkg::ST_EMPTY;
        end else begin
          effective = 1'b1;
          out_d     = entry_w[0];
          count_d   = count_q - 1'b1;
        end
      end
      kdq_pkg::ACT_REMOVE: begin
        // cells shift only where the found chain is set, so no gating needed
        effective = 1'b1;
        if (found_w[DEPTH]) begin
          out_d   = hit_w[DEPTH];
          count_d = count_q - 1'b1;
        end else begin
          status_d = kdq_pkg::ST_NOTFOUND;
        end
      end
      default: effective = 1'b0;
    endcase
  end

  assign ctrl.cap    = accept;
  assign ctrl.exec   = go && effective;
  assign ctrl.action = act_q;

  assign cnt32 = 32'(count_d);

  // the row of slots; cell 0 sees the request as its left neighbour
  assign found_w[0] = 1'b0;
  assign hit_w[0]   = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    kdq_pkg::kdq_entry_t left_e;
    kdq_pkg::kdq_entry_t right_e;
    if (g == 0) begin : g_first
      assign left_e = req_q;
    end else begin : g_mid
      assign left_e = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry_w[g+1];
    end

    kdq_cell #(
      .IDX   (g),
      .CNT_W (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .req_i     (req_q),
      .cmp_key_i (req_i.patient_key),
      .left_i    (left_e),
      .right_i   (right_e),
      .found_i   (found_w[g]),
      .hit_i     (hit_w[g]),
      .entry_o   (entry_w[g]),
      .found_o   (found_w[g+1]),
      .hit_o     (hit_w[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // a new response replacing a drained one keeps valid high
      if (rsp_valid_q && rsp_o.ready && !go) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            state_q     <= S_IDLE;
            count_q     <= count_d;
            rsp_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q     <= kdq_pkg::kdq_action_e'(req_i.action);
      req_q.key <= req_i.patient_key;
      req_q.hdl <= req_i.patient_ref;
    end
    if (go) begin
      status_q <= status_d;
      out_q    <= out_d;
      occ_q    <= cnt32[kdq_pkg::OCC_W-1:0];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.out_key   = out_q.key;
  assign rsp_o.out_ref   = out_q.hdl;
  assign rsp_o.occupancy = occ_q;

  // count never runs past the row length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("occupancy count exceeds depth");

  // failed requests return no entry
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != kdq_pkg::ST_DONE)) |->
      (rsp_o.out_key == '0 && rsp_o.out_ref == '0))
    else $error("failed request returned an entry");

  // a full report comes with a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == kdq_pkg::ST_FULL) |-> (count_q == Full))
    else $error("full reported below depth");

  // an accepted request is executed after it, never alongside it
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC && !req_i.ready))
    else $error("request accepted while another is in flight");

endmodule

>>> tb/kdq_checker.sv
// Watches both channels of the keyed deque, predicts each response and compares it.
module kdq_checker (
  input  logic clk_i,
  input  logic rst_ni,
  kdq_req_if   req_mon,
  kdq_rsp_if   rsp_mon,
  output int   mismatches_o,
  output int   outstanding_o
);
  import kdq_pkg::*;

  typedef struct {
    kdq_status_e      status;
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] hdl;
    logic [OCC_W-1:0] occ;
  } outcome_t;

  kdq_entry_t  rows [KDQ_DEPTH];
  int unsigned held;
  int          rsp_count;
  outcome_t    pending_outcomes [$];

  function automatic logic [7:0] lower_case(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  // case-blind compare up to the first shared terminator
  function automatic bit ids_equal(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    logic [7:0] ca;
    logic [7:0] cb;
    for (int p = 0; p < 8; p++) begin
      ca = lower_case(a[p*8 +: 8]);
      cb = lower_case(b[p*8 +: 8]);
      if (ca != cb) return 1'b0;
      if (ca == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic outcome_t apply_request(kdq_action_e act, logic [KEY_W-1:0] key,
                                             logic [REF_W-1:0] hdl);
    outcome_t o;
    int       hit;
    o.status = ST_DONE;
    o.key    = '0;
    o.hdl    = '0;
    hit      = -1;
    case (act)
      ACT_APPEND, ACT_INSERT: begin
        if (held >= KDQ_DEPTH) begin
          o.status = ST_FULL;
        end else if (act == ACT_APPEND) begin
          rows[held] = {key, hdl};
          held++;
        end else begin
          for (int i = held; i > 0; i--) rows[i] = rows[i-1];
          rows[0] = {key, hdl};
          held++;
        end
      end
      ACT_TAKE: begin
        if (held == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.key = rows[0].key;
          o.hdl = rows[0].hdl;
          held--;
          for (int i = 0; i < held; i++) rows[i] = rows[i+1];
        end
      end
      default: begin
        o.status = ST_NOTFOUND;
        for (int i = 0; i < held; i++)
          if (hit < 0 && ids_equal(rows[i].key, key)) hit = i;
        if (hit >= 0) begin
          o.status = ST_DONE;
          o.key    = rows[hit].key;
          o.hdl    = rows[hit].hdl;
          held--;
          for (int i = hit; i < held; i++) rows[i] = rows[i+1];
        end
      end
    endcase
    o.occ = OCC_W'(held);
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch on response %0d: got %0h, expected %0h",
             $time, field, rsp_count, got, want);
    mismatches_o++;
  endtask

  initial begin
    held          = 0;
    rsp_count     = 0;
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected response, status", rsp_mon.status, '0);
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_mon.status !== want.status)
            report_mismatch("status", rsp_mon.status, want.status);
          if (rsp_mon.out_key !== want.key)
            report_mismatch("out_key", rsp_mon.out_key, want.key);
          if (rsp_mon.out_ref !== want.hdl)
            report_mismatch("out_ref", rsp_mon.out_ref, want.hdl);
          if (rsp_mon.occupancy !== want.occ)
            report_mismatch("occupancy", rsp_mon.occupancy, want.occ);
        end
        rsp_count++;
      end
      if (req_mon.valid && req_mon.ready)
        pending_outcomes.push_back(apply_request(kdq_action_e'(req_mon.action),
                                                 req_mon.patient_key, req_mon.patient_ref));
      outstanding_o = pending_outcomes.size();
    end
  end

endmodule

>>> tb/keyed_deque_with_removal_core_tb.sv
// Stimulus, handshake pacing and verdict for the keyed deque core.
module keyed_deque_with_removal_core_tb;
  import kdq_pkg::*;

  localparam int RAND_ITEMS       = 1320;
  localparam int QUIET_ITEMS      = 150;  // final stretch with no idling on either side
  localparam int PHASE_LEN        = 120;  // requests per grow/shrink phase
  localparam int LONG_HOLD_AT     = 600;  // requests sent before the long response stall
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int STALL_LIMIT      = 2000; // cycles with no handshake before giving up
  localparam int POOL_SIZE        = 12;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   outstanding;
  int   sent_cnt;
  int   stall_cycles;
  bit   quiet;
  bit   long_hold_done;

  logic [KEY_W-1:0] id_pool [POOL_SIZE];
  string            fence_ids [4] = '{"@q", "[q", "`q", "{q"};

  kdq_req_if req_if ();
  kdq_rsp_if rsp_if ();

  keyed_deque_with_removal_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  kdq_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Known values on every input from time zero
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_APPEND;
    req_if.patient_key = '0;
    req_if.patient_ref = '0;
    rsp_if.ready       = 1'b0;
    sent_cnt           = 0;
    quiet              = 1'b0;
    long_hold_done     = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Single reset at start; released on a falling edge, clear of the sampling edge
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Watchdog: give up if neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // First character in the low byte, zero padded
  function automatic logic [KEY_W-1:0] pack_id(string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[i*8 +: 8] = s[i];
    return k;
  endfunction

  // Random identifier of 0..8 bytes: mostly letters, some digits, now and then any byte
  function automatic logic [KEY_W-1:0] make_name();
    logic [KEY_W-1:0] k;
    int               len;
    int               r;
    k   = '0;
    len = $urandom_range(0, 8);
    for (int p = 0; p < len; p++) begin
      r = $urandom_range(0, 9);
      if (r < 4)      k[p*8 +: 8] = 8'($urandom_range(8'h41, 8'h5A));
      else if (r < 8) k[p*8 +: 8] = 8'($urandom_range(8'h61, 8'h7A));
      else if (r < 9) k[p*8 +: 8] = 8'($urandom_range(8'h30, 8'h39));
      else            k[p*8 +: 8] = 8'($urandom_range(1, 255));
    end
    return k;
  endfunction

  // Same identifier with letters flipped in case at random and junk after the terminator
  function automatic logic [KEY_W-1:0] vary_case(logic [KEY_W-1:0] id);
    logic [KEY_W-1:0] k;
    logic [7:0]       c;
    bit               ended;
    k     = id;
    ended = 1'b0;
    for (int p = 0; p < 8; p++) begin
      c = id[p*8 +: 8];
      if (ended) begin
        if ($urandom_range(0, 1)) k[p*8 +: 8] = 8'($urandom_range(0, 255));
      end else if (c == 8'h00) begin
        ended = 1'b1;
      end else if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1)) begin
        k[p*8 +: 8] = c ^ 8'h20;
      end
    end
    return k;
  endfunction

  // Offer one request, called on a falling edge; returns on the falling edge after it is
  // taken. valid stays high into the next request unless a gap is drawn.
  task automatic push_req(kdq_action_e act, logic [KEY_W-1:0] key, logic [REF_W-1:0] hdl);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.action      = act;
    req_if.patient_key = key;
    req_if.patient_ref = hdl;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  // Response side: short random stalls, one long hold-off partway through so that the
  // request side backs up, then always ready for the final stretch.
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && !long_hold_done && sent_cnt >= LONG_HOLD_AT) begin
        rsp_if.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold_done = 1'b1;
        rsp_if.ready   = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        rsp_if.ready = 1'b1;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  initial begin
    kdq_action_e      act;
    logic [KEY_W-1:0] key;
    int               r;
    bit               grow;

    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = make_name();
    wait (rst_ni);
    @(negedge clk_i);

    // ---- directed requests ----
    // take and remove on an empty queue
    push_req(ACT_TAKE, '0, '0);
    push_req(ACT_REMOVE, pack_id("alice"), 32'h1234_5678);
    // special identifiers: mixed case, empty key, no terminator, junk after terminator,
    // and a pair that differ only in case
    push_req(ACT_APPEND, pack_id("Alice"), '0);
    push_req(ACT_INSERT, '0, '1);
    push_req(ACT_APPEND, '1, 32'h0000_0001);
    push_req(ACT_APPEND, pack_id("BOB") | (pack_id("xyz") << 32), 32'hA5A5_5A5A);
    push_req(ACT_APPEND, pack_id("dup"), 32'h0000_0001);
    push_req(ACT_APPEND, pack_id("DUP"), 32'h0000_0002);
    // fill to the brim; the first few sit just outside the upper-case and lower-case ranges
    for (int i = 0; i < 10; i++) begin
      key = (i < 4) ? pack_id(fence_ids[i]) : id_pool[i];
      push_req((i % 2) ? ACT_INSERT : ACT_APPEND, key, $urandom);
    end
    // adds to a full queue at both ends
    push_req(ACT_APPEND, pack_id("x"), $urandom);
    push_req(ACT_INSERT, pack_id("y"), $urandom);
    // removals: miss, case-blind hit, empty key, full eight bytes, junk ignored
    push_req(ACT_REMOVE, pack_id("nobody"), '0);
    push_req(ACT_REMOVE, pack_id("ALICE"), '0);
    push_req(ACT_REMOVE, '0, '0);
    push_req(ACT_REMOVE, '1, '0);
    push_req(ACT_REMOVE, pack_id("bob") | (pack_id("qq") << 32), '0);
    // several matches: only the one nearest the head goes
    push_req(ACT_REMOVE, pack_id("Dup"), '0);
    push_req(ACT_REMOVE, pack_id("dUP"), '0);
    push_req(ACT_TAKE, '0, '0);

    // ---- random requests ----
    // Alternating grow and shrink phases sweep the fill level between empty and full.
    // Keys mostly come from a small pool so that removals find something; a tenth are
    // raw 64-bit noise.
    grow = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) grow = !grow;
      if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < (grow ? 70 : 30)) act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
      else                      act = $urandom_range(0, 1) ? ACT_TAKE : ACT_REMOVE;
      if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
      else                           key = vary_case(id_pool[$urandom_range(0, POOL_SIZE-1)]);
      push_req(act, key, $urandom);
    end
    req_if.valid = 1'b0;

    // drain, then a few more cycles to catch any stray response
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kdq_pkg.sv
rtl/kdq_if.sv
rtl/kdq_cell.sv
rtl/keyed_deque_with_removal_core.sv
tb/kdq_checker.sv
tb/keyed_deque_with_removal_core_tb.sv
